### sv/optok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package optok_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned COUNT_W = 20;
	localparam int unsigned PROD_W  = 24;

	localparam logic [COUNT_W-1:0] MAX_REPEAT_RESET = 20'd100000;

	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_LT     = 8'h3c;
	localparam logic [CHAR_W-1:0] CH_GT     = 8'h3e;
	localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2e;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2c;
	localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5b;
	localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5d;
	localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
	localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
	localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
	localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
	localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
	localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

	typedef enum logic [3:0] {
		OP_INC         = 4'd0,
		OP_DEC         = 4'd1,
		OP_LEFT        = 4'd2,
		OP_MOVE_RIGHT  = 4'd3,
		OP_WAIT        = 4'd4,
		OP_LOOP_OPEN   = 4'd5,
		OP_LOOP_CLOSE  = 4'd6,
		OP_REP_OPEN    = 4'd7,
		OP_REP_CLOSE   = 4'd8,
		OP_INNER_OPEN  = 4'd9,
		OP_INNER_CLOSE = 4'd10,
		OP_DONE        = 4'd11
	} op_t;

	typedef enum logic [2:0] {
		MODE_NORMAL      = 3'd0,
		MODE_AFTER_CLOSE = 3'd1,
		MODE_SIGN        = 3'd2,
		MODE_DIGITS      = 3'd3
	} mode_t;

	// one accepted byte worth of results: op0 always, op1 when pair is set
	typedef struct packed {
		logic               pair;
		op_t                op0;
		logic [COUNT_W-1:0] cnt0;
		op_t                op1;
	} entry_t;

	typedef struct packed {
		logic vld;
		op_t  op;
	} norm_t;

	function automatic logic is_digit(input logic [CHAR_W-1:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic is_cmd(input logic [CHAR_W-1:0] b);
		logic r;
		case (b) inside
			CH_PLUS, CH_MINUS, CH_LT, CH_GT, CH_DOT, CH_COMMA,
			CH_LBRACK, CH_RBRACK, CH_LPAREN, CH_RPAREN,
			CH_LBRACE, CH_RBRACE, CH_STAR, CH_PCT: r = 1'b1;
			default: r = is_digit(b);
		endcase
		return r;
	endfunction

	// op for a byte in normal scanning; ')' is handled by the caller
	function automatic norm_t normal_op(input logic [CHAR_W-1:0] b);
		norm_t r;
		r.vld = 1'b1;
		r.op  = OP_INC;
		case (b)
			CH_PLUS:   r.op = OP_INC;
			CH_MINUS:  r.op = OP_DEC;
			CH_LT:     r.op = OP_LEFT;
			CH_GT:     r.op = OP_MOVE_RIGHT;
			CH_DOT:    r.op = OP_WAIT;
			CH_LBRACK: r.op = OP_LOOP_OPEN;
			CH_RBRACK: r.op = OP_LOOP_CLOSE;
			CH_LPAREN: r.op = OP_REP_OPEN;
			CH_LBRACE: r.op = OP_INNER_OPEN;
			CH_RBRACE: r.op = OP_INNER_CLOSE;
			default:   r.vld = 1'b0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/optok_front.sv
`timescale 1ns / 1ps
`default_nettype none
module optok_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [19:0]                 cfg_wdata,
	input  wire logic                        accept,
	input  wire logic [7:0]                  char_byte,
	input  wire logic                        end_of_input,
	output logic                             ent_push,
	output optok_pkg::entry_t                ent
);
	import optok_pkg::*;

	logic [COUNT_W-1:0] max_repeat_q;
	mode_t              mode_q, mode_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               neg_q, neg_d;

	logic [PROD_W-1:0]  prod;
	logic [COUNT_W-1:0] settled;
	logic               emit;
	logic               do_close;
	logic [COUNT_W-1:0] close_cnt;
	norm_t              nr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_repeat_q <= MAX_REPEAT_RESET;
		end else if (cfg_we) begin
			max_repeat_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			count_q <= '0;
			neg_q   <= 1'b0;
		end else if (accept) begin
			mode_q  <= mode_d;
			count_q <= count_d;
			neg_q   <= neg_d;
		end
	end

	always_comb begin
		prod = PROD_W'({count_q, 3'b000}) + PROD_W'({count_q, 1'b0})
			+ PROD_W'(char_byte[3:0]);
		settled = (neg_q && (count_q != '0)) ? max_repeat_q : count_q;
		nr = normal_op(char_byte);

		mode_d    = mode_q;
		count_d   = count_q;
		neg_d     = neg_q;
		emit      = 1'b0;
		do_close  = 1'b0;
		close_cnt = '0;
		ent.pair  = 1'b0;
		ent.op0   = OP_DONE;
		ent.cnt0  = '0;
		ent.op1   = OP_DONE;

		if (end_of_input) begin
			emit    = 1'b1;
			mode_d  = MODE_NORMAL;
			count_d = '0;
			neg_d   = 1'b0;
			if (mode_q inside {MODE_AFTER_CLOSE, MODE_SIGN, MODE_DIGITS}) begin
				ent.pair = 1'b1;
				ent.op0  = OP_REP_CLOSE;
				ent.cnt0 = settled;
			end
		end else begin
			case (mode_q)
				MODE_AFTER_CLOSE: begin
					if (is_cmd(char_byte)) begin
						if (char_byte == CH_STAR || char_byte == CH_PCT) begin
							mode_d = MODE_SIGN;
						end else begin
							do_close = 1'b1;
						end
					end
				end
				MODE_SIGN: begin
					if (is_cmd(char_byte)) begin
						if (char_byte == CH_MINUS) begin
							neg_d  = 1'b1;
							mode_d = MODE_DIGITS;
						end else if (is_digit(char_byte)) begin
							mode_d = MODE_DIGITS;
							if (prod > PROD_W'(max_repeat_q)) begin
								emit     = 1'b1;
								ent.op0  = OP_REP_CLOSE;
								ent.cnt0 = max_repeat_q;
								mode_d   = MODE_NORMAL;
								count_d  = '0;
								neg_d    = 1'b0;
							end else begin
								count_d = prod[COUNT_W-1:0];
							end
						end else begin
							do_close = 1'b1;
						end
					end
				end
				MODE_DIGITS: begin
					if (is_digit(char_byte)) begin
						if (prod > PROD_W'(max_repeat_q)) begin
							emit     = 1'b1;
							ent.op0  = OP_REP_CLOSE;
							ent.cnt0 = max_repeat_q;
							mode_d   = MODE_NORMAL;
							count_d  = '0;
							neg_d    = 1'b0;
						end else begin
							count_d = prod[COUNT_W-1:0];
						end
					end else begin
						do_close  = 1'b1;
						close_cnt = settled;
					end
				end
				default: begin
					mode_d = MODE_NORMAL;
					if (char_byte == CH_RPAREN) begin
						mode_d  = MODE_AFTER_CLOSE;
						count_d = '0;
						neg_d   = 1'b0;
					end else if (nr.vld) begin
						emit    = 1'b1;
						ent.op0 = nr.op;
					end
				end
			endcase

			// pending close, then the same byte again as a command
			if (do_close) begin
				emit     = 1'b1;
				ent.op0  = OP_REP_CLOSE;
				ent.cnt0 = close_cnt;
				mode_d   = MODE_NORMAL;
				count_d  = '0;
				neg_d    = 1'b0;
				if (char_byte == CH_RPAREN) begin
					mode_d = MODE_AFTER_CLOSE;
				end else if (nr.vld) begin
					ent.pair = 1'b1;
					ent.op1  = nr.op;
				end
			end
		end

		ent_push = accept && emit;
	end

endmodule
`default_nettype wire

### sv/optok_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module optok_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire optok_pkg::entry_t wr_ent,
	output logic                   q_full,
	output logic                   q_empty,
	input  wire logic              rd_en,
	output optok_pkg::entry_t      rd_ent
);
	import optok_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_wr, do_rd;

	assign q_full  = (cnt_q == FULL_CNT);
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;
	assign rd_ent  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

### sv/optok_back.sv
`timescale 1ns / 1ps
`default_nettype none
module optok_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire optok_pkg::entry_t head,
	input  wire logic              head_empty,
	output logic                   head_pop,
	input  wire logic              pop,
	output logic [3:0]             op_code,
	output logic [19:0]            repeat_count,
	output logic                   last_result
);
	import optok_pkg::*;

	logic sub_q;
	logic take;

	assign take         = pop && !head_empty;
	assign op_code      = sub_q ? 4'(head.op1) : 4'(head.op0);
	assign repeat_count = sub_q ? '0 : head.cnt0;
	assign last_result  = sub_q || !head.pair;
	assign head_pop     = take && (sub_q || !head.pair);

	// second result of a pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q <= 1'b0;
		end else if (take) begin
			sub_q <= head.pair && !sub_q;
		end
	end

endmodule
`default_nettype wire

### sv/op_tokenizer_with_repeat_count.sv
`timescale 1ns / 1ps
`default_nettype none
// a result is registered in the queue, and the result ports show the queue head
// throughput: one byte per cycle while the queue is not full; a byte that yields two
// results holds the QUEUE_DEPTH-entry queue head for two pops (one result port)
// reset: arst_n clears scan state and the queue at once, max_repeat returns to 100000
module op_tokenizer_with_repeat_count #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [19:0] cfg_wdata,
	input  wire logic        push,
	output logic             full,
	input  wire logic [7:0]  char_byte,
	input  wire logic        end_of_input,
	output logic             empty,
	input  wire logic        pop,
	output logic [3:0]       op_code,
	output logic [19:0]      repeat_count,
	output logic             last_result
);
	import optok_pkg::*;

	logic   accept;
	logic   ent_push;
	entry_t ent;
	entry_t head;
	logic   head_pop;

	assign accept = push && !full;

	optok_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.accept       (accept),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.ent_push     (ent_push),
		.ent          (ent)
	);

	optok_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (ent_push),
		.wr_ent  (ent),
		.q_full  (full),
		.q_empty (empty),
		.rd_en   (head_pop),
		.rd_ent  (head)
	);

	optok_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_empty   (empty),
		.head_pop     (head_pop),
		.pop          (pop),
		.op_code      (op_code),
		.repeat_count (repeat_count),
		.last_result  (last_result)
	);

`ifndef ASSERT_OFF
	a_count_only_on_close: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && op_code != OP_REP_CLOSE |-> repeat_count == '0)
		else $error("nonzero count on an op other than rep close");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && op_code == OP_DONE |-> last_result)
		else $error("done is not the last result of its transaction");

	a_first_of_pair_is_close: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !last_result |-> op_code == OP_REP_CLOSE)
		else $error("first of two results is not rep close");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full && end_of_input |=> !empty)
		else $error("end of input left no result waiting");
`endif

endmodule
`default_nettype wire
